@@ rtl/rgb888_to_rgb565_tint_preserving_defines.svh @@
// Assertion macros shared by the checker of the RGB888 to RGB565 quantizer.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef RGB888_TO_RGB565_TINT_PRESERVING_DEFINES_SVH
`define RGB888_TO_RGB565_TINT_PRESERVING_DEFINES_SVH

// Check a same-cycle implication, off while reset is held.
`define RTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtq assertion failed");

// Check an implication in the following cycle, off while reset is held.
`define RTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtq assertion failed");

`endif

@@ rtl/rtq_pkg.sv @@
// Shared types, candidate counts and level helpers of the RGB888 to RGB565 quantizer.
// Depends on nothing; the top level, rtq_front, rtq_cost and rtq_select import it.
package rtq_pkg;

    localparam int NR      = 3;        // red candidates, offsets -1..+1
    localparam int NG      = 5;        // green candidates, offsets -2..+2
    localparam int NB      = 3;        // blue candidates, offsets -1..+1
    localparam int NGRP    = NR * NG;  // red/green groups
    localparam int NC      = NGRP * NB;
    localparam int RED_OFS = 1;
    localparam int GRN_OFS = 2;
    localparam int BLU_OFS = 1;

    typedef logic signed [8:0]  t_err;   // expanded level minus input
    typedef logic signed [10:0] t_sum;   // sum of three errors
    typedef logic [17:0]        t_sq4;   // four times a squared error
    typedef logic [19:0]        t_cost;  // cost scaled down by nine
    typedef logic [4:0]         t_lvl5;
    typedef logic [5:0]         t_lvl6;

    typedef struct packed {
        t_lvl5 [NR-1:0] red;
        t_lvl6 [NG-1:0] green;
        t_lvl5 [NB-1:0] blue;
        logic  [NR-1:0] red_ok;
        logic  [NG-1:0] green_ok;
        logic  [NB-1:0] blue_ok;
    } t_cand;

    // Nearest 5-bit level: (v*31+127)/255, quotient by x>>8 and one correction.
    function automatic t_lvl5 round5(input logic [7:0] v);
        logic [12:0] x;
        logic [4:0]  q;
        logic [8:0]  rem;
        x   = 13'(v) * 13'd31 + 13'd127;
        q   = x[12:8];
        rem = {1'b0, x[7:0]} + {4'b0000, q};
        if (rem >= 9'd255) begin
            q = q + 5'd1;
        end
        return q;
    endfunction

    // Nearest 6-bit level: (v*63+127)/255.
    function automatic t_lvl6 round6(input logic [7:0] v);
        logic [13:0] x;
        logic [5:0]  q;
        logic [8:0]  rem;
        x   = 14'(v) * 14'd63 + 14'd127;
        q   = x[13:8];
        rem = {1'b0, x[7:0]} + {3'b000, q};
        if (rem >= 9'd255) begin
            q = q + 6'd1;
        end
        return q;
    endfunction

    function automatic logic [7:0] expand5(input t_lvl5 l);
        return {l, l[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input t_lvl6 l);
        return {l, l[5:4]};
    endfunction

endpackage

@@ rtl/rtq_pix_in_if.sv @@
// Input pixel channel of the quantizer: valid/ready handshake with a 24-bit colour.
// Depends on nothing.
interface rtq_pix_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] rgb_in;

    modport source (output valid, output rgb_in, input ready);
    modport sink   (input valid, input rgb_in, output ready);
endinterface

@@ rtl/rtq_pix_out_if.sv @@
// Output pixel channel of the quantizer: valid/ready handshake with 5/6/5 levels.
// Depends on nothing.
interface rtq_pix_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] red_level;
    logic [5:0] green_level;
    logic [4:0] blue_level;

    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink   (input valid, input red_level, input green_level, input blue_level,
                    output ready);
endinterface

@@ rtl/rgb888_to_rgb565_tint_preserving.sv @@
// RGB888 to RGB565 quantizer that keeps the tint of the input colour.
// Depends on rtq_pkg, the two channel interfaces, rtq_front, rtq_cost and rtq_select.
//
// Usage:
//   i_pix carries one 24-bit colour per transaction (red 23..16, green 15..8,
//   blue 7..0); o_pix returns the chosen 5/6/5 levels, one transaction for each
//   input transaction, in order. A transaction completes when valid and ready
//   are both high at a rising edge of i_clk.
//   Each transaction passes through seven register stages: rounding, neighbor
//   errors, squares, candidate costs and a three-level minimum tree over the
//   45 candidates. Throughput is one colour per cycle while o_pix.ready
//   is high; each stage holds one item.
//   i_rst_n is synchronous and active low; it empties every stage, and i_pix.ready
//   is high from the first cycle after reset.
//   When the receiver holds o_pix.ready low, the output register holds its
//   levels; earlier stages keep filling empty slots, and i_pix.ready drops only
//   once every stage holds an item.
module rgb888_to_rgb565_tint_preserving import rtq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtq_pix_in_if.sink    i_pix,
    rtq_pix_out_if.source o_pix
);

    logic          front_vld;
    logic          front_rdy;
    t_cand         front_cand;
    t_err          front_err_r [NR];
    t_err          front_err_g [NG];
    t_err          front_err_b [NB];

    logic          cost_vld;
    logic          cost_rdy;
    t_cand         cost_cand;
    t_cost         cost_val [NC];
    logic [NC-1:0] cost_ok;

    logic          sel_rdy;

    rtq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_pix.valid),
        .o_rdy   (front_rdy),
        .i_rgb   (i_pix.rgb_in),
        .o_vld   (front_vld),
        .i_rdy   (cost_rdy),
        .o_cand  (front_cand),
        .o_err_r (front_err_r),
        .o_err_g (front_err_g),
        .o_err_b (front_err_b)
    );

    rtq_cost u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .o_rdy   (cost_rdy),
        .i_cand  (front_cand),
        .i_err_r (front_err_r),
        .i_err_g (front_err_g),
        .i_err_b (front_err_b),
        .o_vld   (cost_vld),
        .i_rdy   (sel_rdy),
        .o_cand  (cost_cand),
        .o_cost  (cost_val),
        .o_ok    (cost_ok)
    );

    rtq_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cost_vld),
        .o_rdy   (sel_rdy),
        .i_cand  (cost_cand),
        .i_cost  (cost_val),
        .i_ok    (cost_ok),
        .o_vld   (o_pix.valid),
        .i_rdy   (o_pix.ready),
        .o_red   (o_pix.red_level),
        .o_grn   (o_pix.green_level),
        .o_blu   (o_pix.blue_level)
    );

    assign i_pix.ready = front_rdy;

endmodule

@@ rtl/rtq_front.sv @@
// Front stages: round each channel to its level, then build neighbor levels and errors.
// Depends on rtq_pkg.
module rtq_front import rtq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  logic [23:0] i_rgb,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_cand       o_cand,
    output t_err        o_err_r [NR],
    output t_err        o_err_g [NG],
    output t_err        o_err_b [NB]
);

    logic       r_s1_vld;
    logic [7:0] r_red;
    logic [7:0] r_grn;
    logic [7:0] r_blu;
    t_lvl5      r_red0;
    t_lvl6      r_grn0;
    t_lvl5      r_blu0;

    logic       r_s2_vld;
    t_cand      r_cand;
    t_err       r_err_r [NR];
    t_err       r_err_g [NG];
    t_err       r_err_b [NB];

    t_cand      n_cand;
    t_err       n_err_r [NR];
    t_err       n_err_g [NG];
    t_err       n_err_b [NB];

    logic       s1_ce;
    logic       s2_ce;

    // Advance a stage when it is empty or the next one advances.
    assign s2_ce = !r_s2_vld || i_rdy;
    assign s1_ce = !r_s1_vld || s2_ce;
    assign o_rdy = s1_ce;

    always_comb begin
        logic signed [6:0] v5;
        logic signed [7:0] v6;
        n_cand = '0;
        for (int i = 0; i < NR; i++) begin
            v5 = $signed({2'b00, r_red0}) + $signed(7'(i - RED_OFS));
            n_cand.red[i]    = v5[4:0];
            // out of range when negative or above the top level
            n_cand.red_ok[i] = !v5[6] && !v5[5];
            n_err_r[i] = $signed({1'b0, expand5(v5[4:0])}) - $signed({1'b0, r_red});
        end
        for (int i = 0; i < NG; i++) begin
            v6 = $signed({2'b00, r_grn0}) + $signed(8'(i - GRN_OFS));
            n_cand.green[i]    = v6[5:0];
            n_cand.green_ok[i] = !v6[7] && !v6[6];
            n_err_g[i] = $signed({1'b0, expand6(v6[5:0])}) - $signed({1'b0, r_grn});
        end
        for (int i = 0; i < NB; i++) begin
            v5 = $signed({2'b00, r_blu0}) + $signed(7'(i - BLU_OFS));
            n_cand.blue[i]    = v5[4:0];
            n_cand.blue_ok[i] = !v5[6] && !v5[5];
            n_err_b[i] = $signed({1'b0, expand5(v5[4:0])}) - $signed({1'b0, r_blu});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_ce) begin
                r_s1_vld <= i_vld;
            end
            if (s2_ce) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ce) begin
            r_red  <= i_rgb[23:16];
            r_grn  <= i_rgb[15:8];
            r_blu  <= i_rgb[7:0];
            r_red0 <= round5(i_rgb[23:16]);
            r_grn0 <= round6(i_rgb[15:8]);
            r_blu0 <= round5(i_rgb[7:0]);
        end
        if (s2_ce) begin
            r_cand  <= n_cand;
            r_err_r <= n_err_r;
            r_err_g <= n_err_g;
            r_err_b <= n_err_b;
        end
    end

    assign o_vld   = r_s2_vld;
    assign o_cand  = r_cand;
    assign o_err_r = r_err_r;
    assign o_err_g = r_err_g;
    assign o_err_b = r_err_b;

endmodule

@@ rtl/rtq_cost.sv @@
// Cost stages: per-channel squares and error sums, then one cost per candidate.
// Cost is 4*(eR^2+eG^2+eB^2) - (eR+eG+eB)^2, the exact metric divided by nine. Uses rtq_pkg.
module rtq_cost import rtq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  t_cand       i_cand,
    input  t_err        i_err_r [NR],
    input  t_err        i_err_g [NG],
    input  t_err        i_err_b [NB],
    output logic        o_vld,
    input  logic        i_rdy,
    output t_cand       o_cand,
    output t_cost       o_cost [NC],
    output logic [NC-1:0] o_ok
);

    logic          r_s3_vld;
    t_cand         r_cand3;
    t_sq4          r_q4r [NR];
    t_sq4          r_q4g [NG];
    t_sq4          r_q4b [NB];
    t_sum          r_sum [NC];

    logic          r_s4_vld;
    t_cand         r_cand4;
    t_cost         r_cost [NC];
    logic [NC-1:0] r_ok;

    t_sq4          n_q4r [NR];
    t_sq4          n_q4g [NG];
    t_sq4          n_q4b [NB];
    t_sum          n_sum [NC];
    t_cost         n_cost [NC];
    logic [NC-1:0] n_ok;

    logic          s3_ce;
    logic          s4_ce;

    assign s4_ce = !r_s4_vld || i_rdy;
    assign s3_ce = !r_s3_vld || s4_ce;
    assign o_rdy = s3_ce;

    always_comb begin
        logic signed [17:0] p;
        for (int i = 0; i < NR; i++) begin
            p = i_err_r[i] * i_err_r[i];
            n_q4r[i] = {p[15:0], 2'b00};
        end
        for (int i = 0; i < NG; i++) begin
            p = i_err_g[i] * i_err_g[i];
            n_q4g[i] = {p[15:0], 2'b00};
        end
        for (int i = 0; i < NB; i++) begin
            p = i_err_b[i] * i_err_b[i];
            n_q4b[i] = {p[15:0], 2'b00};
        end
        for (int i = 0; i < NR; i++) begin
            for (int j = 0; j < NG; j++) begin
                for (int k = 0; k < NB; k++) begin
                    n_sum[(i * NG + j) * NB + k] =
                        {{2{i_err_r[i][8]}}, i_err_r[i]} +
                        {{2{i_err_g[j][8]}}, i_err_g[j]} +
                        {{2{i_err_b[k][8]}}, i_err_b[k]};
                end
            end
        end
    end

    always_comb begin
        logic signed [21:0] ps;
        for (int i = 0; i < NR; i++) begin
            for (int j = 0; j < NG; j++) begin
                for (int k = 0; k < NB; k++) begin
                    ps = r_sum[(i * NG + j) * NB + k] * r_sum[(i * NG + j) * NB + k];
                    // never negative: the squared sum is at most three times the squares
                    n_cost[(i * NG + j) * NB + k] =
                        20'(r_q4r[i]) + 20'(r_q4g[j]) + 20'(r_q4b[k]) - ps[19:0];
                    n_ok[(i * NG + j) * NB + k] =
                        r_cand3.red_ok[i] && r_cand3.green_ok[j] && r_cand3.blue_ok[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (s3_ce) begin
                r_s3_vld <= i_vld;
            end
            if (s4_ce) begin
                r_s4_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ce) begin
            r_cand3 <= i_cand;
            r_q4r   <= n_q4r;
            r_q4g   <= n_q4g;
            r_q4b   <= n_q4b;
            r_sum   <= n_sum;
        end
        if (s4_ce) begin
            r_cand4 <= r_cand3;
            r_cost  <= n_cost;
            r_ok    <= n_ok;
        end
    end

    assign o_vld  = r_s4_vld;
    assign o_cand = r_cand4;
    assign o_cost = r_cost;
    assign o_ok   = r_ok;

endmodule

@@ rtl/rtq_select.sv @@
// Selection stages: registered minimum tree over blue, then green, then red offsets.
// A later candidate wins only on a strictly lower cost, so ties keep loop order. Uses rtq_pkg.
module rtq_select import rtq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  t_cand         i_cand,
    input  t_cost         i_cost [NC],
    input  logic [NC-1:0] i_ok,
    output logic          o_vld,
    input  logic          i_rdy,
    output t_lvl5         o_red,
    output t_lvl6         o_grn,
    output t_lvl5         o_blu
);

    logic            r_s5_vld;
    t_cand           r_cand5;
    t_cost           r_g_cost [NGRP];
    t_lvl5           r_g_blu  [NGRP];
    logic [NGRP-1:0] r_g_ok;

    logic            r_s6_vld;
    t_cand           r_cand6;
    t_cost           r_r_cost [NR];
    t_lvl6           r_r_grn  [NR];
    t_lvl5           r_r_blu  [NR];
    logic [NR-1:0]   r_r_ok;

    logic            r_s7_vld;
    t_lvl5           r_red;
    t_lvl6           r_grn;
    t_lvl5           r_blu;

    t_cost           n_g_cost [NGRP];
    t_lvl5           n_g_blu  [NGRP];
    logic [NGRP-1:0] n_g_ok;
    t_cost           n_r_cost [NR];
    t_lvl6           n_r_grn  [NR];
    t_lvl5           n_r_blu  [NR];
    logic [NR-1:0]   n_r_ok;
    t_lvl5           n_red;
    t_lvl6           n_grn;
    t_lvl5           n_blu;

    logic            s5_ce;
    logic            s6_ce;
    logic            s7_ce;

    assign s7_ce = !r_s7_vld || i_rdy;
    assign s6_ce = !r_s6_vld || s7_ce;
    assign s5_ce = !r_s5_vld || s6_ce;
    assign o_rdy = s5_ce;

    // Best blue offset within each red/green group.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_g_cost[g] = '0;
            n_g_blu[g]  = '0;
            n_g_ok[g]   = 1'b0;
            for (int k = 0; k < NB; k++) begin
                if (i_ok[g * NB + k] && (!n_g_ok[g] || i_cost[g * NB + k] < n_g_cost[g])) begin
                    n_g_ok[g]   = 1'b1;
                    n_g_cost[g] = i_cost[g * NB + k];
                    n_g_blu[g]  = i_cand.blue[k];
                end
            end
        end
    end

    // Best green offset for each red offset.
    always_comb begin
        for (int i = 0; i < NR; i++) begin
            n_r_cost[i] = '0;
            n_r_grn[i]  = '0;
            n_r_blu[i]  = '0;
            n_r_ok[i]   = 1'b0;
            for (int j = 0; j < NG; j++) begin
                if (r_g_ok[i * NG + j] &&
                    (!n_r_ok[i] || r_g_cost[i * NG + j] < n_r_cost[i])) begin
                    n_r_ok[i]   = 1'b1;
                    n_r_cost[i] = r_g_cost[i * NG + j];
                    n_r_grn[i]  = r_cand5.green[j];
                    n_r_blu[i]  = r_g_blu[i * NG + j];
                end
            end
        end
    end

    // Best red offset; the rounded center is always in range, so one wins.
    always_comb begin
        t_cost best;
        logic  have;
        best  = '0;
        have  = 1'b0;
        n_red = '0;
        n_grn = '0;
        n_blu = '0;
        for (int i = 0; i < NR; i++) begin
            if (r_r_ok[i] && (!have || r_r_cost[i] < best)) begin
                have  = 1'b1;
                best  = r_r_cost[i];
                n_red = r_cand6.red[i];
                n_grn = r_r_grn[i];
                n_blu = r_r_blu[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            if (s5_ce) begin
                r_s5_vld <= i_vld;
            end
            if (s6_ce) begin
                r_s6_vld <= r_s5_vld;
            end
            if (s7_ce) begin
                r_s7_vld <= r_s6_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_ce) begin
            r_cand5  <= i_cand;
            r_g_cost <= n_g_cost;
            r_g_blu  <= n_g_blu;
            r_g_ok   <= n_g_ok;
        end
        if (s6_ce) begin
            r_cand6  <= r_cand5;
            r_r_cost <= n_r_cost;
            r_r_grn  <= n_r_grn;
            r_r_blu  <= n_r_blu;
            r_r_ok   <= n_r_ok;
        end
        if (s7_ce) begin
            r_red <= n_red;
            r_grn <= n_grn;
            r_blu <= n_blu;
        end
    end

    assign o_vld = r_s7_vld;
    assign o_red = r_red;
    assign o_grn = r_grn;
    assign o_blu = r_blu;

endmodule

@@ rtl/rtq_checker.sv @@
// Port-level checker for the RGB888 to RGB565 quantizer, bound to the top level.
// Depends on the assertion macros in rgb888_to_rgb565_tint_preserving_defines.svh.
`include "rgb888_to_rgb565_tint_preserving_defines.svh"

module rtq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_levels
);

    // A stalled result stays offered with the same levels.
    `RTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_levels))

    // An open output lets every stage advance, so the input is open too.
    `RTQ_ASSERT_NOW(a_ready_flow, i_clk, i_rst_n, i_out_ready, i_in_ready)

    // Back-pressure at the input only comes from a stalled output.
    `RTQ_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // Reset empties the pipeline.
    `RTQ_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !i_out_valid)

endmodule

bind rgb888_to_rgb565_tint_preserving rtq_checker u_rtq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_out_levels ({o_pix.red_level, o_pix.green_level, o_pix.blue_level})
);
